[rtl/core/edt_pkg.sv]
`timescale 1ns / 1ps

package edt_pkg;

    localparam int unsigned ADDR_W   = 6;
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_DELIM_MASK_0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DELIM_MASK_1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DELIM_MASK_2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DELIM_MASK_3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ESCAPE_EN    = 3'd4;

    localparam logic [7:0] BACKSLASH = 8'h5C;

    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_END_TOKEN = 2'd1;
    localparam logic [1:0] KIND_END_TEXT  = 2'd2;

    // Result slots of one command, in emission order.
    localparam int unsigned FLAG_BS        = 0;
    localparam int unsigned FLAG_CHAR      = 1;
    localparam int unsigned FLAG_BS_EOT    = 2;
    localparam int unsigned FLAG_END_TOKEN = 3;
    localparam int unsigned FLAG_END_TEXT  = 4;
    localparam int unsigned NUM_FLAGS      = 5;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_valid;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [255:0] delim_mask;
        logic         escape_enable;
    } t_cfg;

    typedef struct packed {
        logic [NUM_FLAGS-1:0] flags;
        logic [7:0]           char_byte;
    } t_cmd;

endpackage

[rtl/core/edt_regs.sv]
`timescale 1ns / 1ps

module edt_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [edt_pkg::ADDR_W-1:0] paddr,
    input  logic [edt_pkg::DATA_W-1:0] pwdata,
    output logic [edt_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output edt_pkg::t_cfg              o_cfg
);

    logic [63:0] r_delim_0;
    logic [63:0] r_delim_1;
    logic [63:0] r_delim_2;
    logic [63:0] r_delim_3;
    logic        r_escape_en;
    logic [edt_pkg::REG_IDX_W-1:0] idx;
    logic        wr;

    assign idx    = paddr[edt_pkg::ADDR_W-1:3];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_0   <= '0;
            r_delim_1   <= '0;
            r_delim_2   <= '0;
            r_delim_3   <= '0;
            r_escape_en <= 1'b0;
        end else if (wr) begin
            case (idx)
                edt_pkg::REG_DELIM_MASK_0: r_delim_0   <= pwdata;
                edt_pkg::REG_DELIM_MASK_1: r_delim_1   <= pwdata;
                edt_pkg::REG_DELIM_MASK_2: r_delim_2   <= pwdata;
                edt_pkg::REG_DELIM_MASK_3: r_delim_3   <= pwdata;
                edt_pkg::REG_ESCAPE_EN:    r_escape_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            edt_pkg::REG_DELIM_MASK_0: prdata = r_delim_0;
            edt_pkg::REG_DELIM_MASK_1: prdata = r_delim_1;
            edt_pkg::REG_DELIM_MASK_2: prdata = r_delim_2;
            edt_pkg::REG_DELIM_MASK_3: prdata = r_delim_3;
            edt_pkg::REG_ESCAPE_EN:    prdata = {63'd0, r_escape_en};
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.delim_mask    = {r_delim_3, r_delim_2, r_delim_1, r_delim_0};
    assign o_cfg.escape_enable = r_escape_en;

endmodule

[rtl/core/edt_front.sv]
`timescale 1ns / 1ps

module edt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  edt_pkg::t_cfg     i_cfg,
    input  logic              i_accept,
    input  edt_pkg::t_in_item i_item,
    output logic              o_push,
    output edt_pkg::t_cmd     o_cmd
);

    logic r_inside;
    logic r_pending;
    logic r_has_chars;
    logic n_inside;
    logic n_pending;
    logic n_has_chars;
    logic is_delim;
    logic [edt_pkg::NUM_FLAGS-1:0] flags;

    assign is_delim = i_cfg.delim_mask[i_item.in_byte];

    always_comb begin
        n_inside    = r_inside;
        n_pending   = r_pending;
        n_has_chars = r_has_chars;
        flags       = '0;
        if (i_item.byte_valid) begin
            if (is_delim) begin
                if (!r_inside) begin
                    n_inside = r_inside;
                end else if (r_pending) begin
                    n_pending = 1'b0;
                    flags[edt_pkg::FLAG_CHAR] = 1'b1;
                    n_has_chars = 1'b1;
                end else begin
                    flags[edt_pkg::FLAG_END_TOKEN] = r_has_chars;
                    n_inside    = 1'b0;
                    n_has_chars = 1'b0;
                end
            end else if (i_cfg.escape_enable && i_item.in_byte == edt_pkg::BACKSLASH) begin
                n_inside = 1'b1;
                if (r_pending) begin
                    n_pending = 1'b0;
                    flags[edt_pkg::FLAG_CHAR] = 1'b1;
                    n_has_chars = 1'b1;
                end else begin
                    n_pending = 1'b1;
                end
            end else begin
                n_inside = 1'b1;
                flags[edt_pkg::FLAG_BS]   = r_pending;
                n_pending = 1'b0;
                flags[edt_pkg::FLAG_CHAR] = 1'b1;
                n_has_chars = 1'b1;
            end
        end
        if (i_item.end_of_text) begin
            if (n_pending) begin
                flags[edt_pkg::FLAG_BS_EOT] = 1'b1;
                n_has_chars = 1'b1;
            end
            if (n_has_chars) begin
                flags[edt_pkg::FLAG_END_TOKEN] = 1'b1;
            end
            flags[edt_pkg::FLAG_END_TEXT] = 1'b1;
            n_inside    = 1'b0;
            n_pending   = 1'b0;
            n_has_chars = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside    <= 1'b0;
            r_pending   <= 1'b0;
            r_has_chars <= 1'b0;
        end else if (i_accept) begin
            r_inside    <= n_inside;
            r_pending   <= n_pending;
            r_has_chars <= n_has_chars;
        end
    end

    assign o_push          = i_accept && (flags != '0);
    assign o_cmd.flags     = flags;
    assign o_cmd.char_byte = i_item.in_byte;

endmodule

[rtl/core/edt_queue.sv]
`timescale 1ns / 1ps

module edt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  edt_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output edt_pkg::t_cmd o_cmd
);

    edt_pkg::t_cmd r_mem [edt_pkg::QUEUE_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'(edt_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(edt_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

endmodule

[rtl/core/edt_back.sv]
`timescale 1ns / 1ps

module edt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  edt_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    output edt_pkg::t_out_item o_item,
    input  logic               i_stall
);

    logic                          r_busy;
    edt_pkg::t_cmd                 r_cmd;
    logic [edt_pkg::NUM_FLAGS-1:0] sel;
    logic [edt_pkg::NUM_FLAGS-1:0] remain;
    logic                          last;
    logic                          xfer;

    assign sel    = r_cmd.flags & (-r_cmd.flags);
    assign remain = r_cmd.flags & ~sel;
    assign last   = (remain == '0);
    assign xfer   = r_busy && !i_stall;
    assign o_pop  = !i_empty && (!r_busy || (xfer && last));

    always_comb begin
        o_item.last_of_run = last;
        if (sel[edt_pkg::FLAG_BS] || sel[edt_pkg::FLAG_BS_EOT]) begin
            o_item.out_byte = edt_pkg::BACKSLASH;
            o_item.kind     = edt_pkg::KIND_CHAR;
        end else if (sel[edt_pkg::FLAG_CHAR]) begin
            o_item.out_byte = r_cmd.char_byte;
            o_item.kind     = edt_pkg::KIND_CHAR;
        end else if (sel[edt_pkg::FLAG_END_TOKEN]) begin
            o_item.out_byte = 8'd0;
            o_item.kind     = edt_pkg::KIND_END_TOKEN;
        end else begin
            o_item.out_byte = 8'd0;
            o_item.kind     = edt_pkg::KIND_END_TEXT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cmd.flags <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_cmd  <= i_cmd;
        end else if (xfer) begin
            r_busy      <= !last;
            r_cmd.flags <= remain;
        end
    end

    assign o_valid = r_busy;

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cmd.flags != '0))
        else $error("result pending with no slots left");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && !last) |=> r_busy)
        else $error("run dropped before its last result");

endmodule

[rtl/core/escaped_delimiter_tokenizer_core.sv]
`timescale 1ns / 1ps

// Byte-stream tokenizer with backslash escape. One input transfer carries one
// byte and/or an end-of-text flag; it yields zero to four result transfers
// (characters, end-of-token, end-of-text), the last one flagged last_of_run.
// The front end takes one input transfer per cycle while its two-entry
// command queue has room; the back end drives one result per cycle from the
// queue head unless the output stalls, each item taking one transfer per
// result (two for an escaped ordinary byte, up to four at end of text);
// items with no result are not queued. Results pass through the queue and
// a back-end register. Registers sit at byte address 8*index on a 64-bit
// APB port and should be written only while no results are pending.
module escaped_delimiter_tokenizer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [edt_pkg::ADDR_W-1:0] paddr,
    input  logic [edt_pkg::DATA_W-1:0] pwdata,
    output logic [edt_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    input  edt_pkg::t_in_item          i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output edt_pkg::t_out_item         o_out_data,
    input  logic                       i_out_stall
);

    edt_pkg::t_cfg cfg;
    edt_pkg::t_cmd push_cmd;
    edt_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    logic          in_accept;

    assign o_in_stall = full;
    assign in_accept  = i_in_valid && !full;

    edt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    edt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    edt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    edt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_item  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

[verif/escaped_delimiter_tokenizer_core_test.sv]
`timescale 1ns / 1ps

module escaped_delimiter_tokenizer_core_test;

    localparam int unsigned RANDOM_ITEMS = 435;
    localparam int unsigned PHASES       = 5;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam logic [2:0]  USE_MODEL    = 3'd7;

    typedef struct packed {
        logic               esc_off;
        edt_pkg::t_in_item  item;
        logic [2:0]         n_fix;
        edt_pkg::t_out_item fix0;
        edt_pkg::t_out_item fix1;
        edt_pkg::t_out_item fix2;
    } t_dir_row;

    localparam edt_pkg::t_out_item NO_RES = '0;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [edt_pkg::ADDR_W-1:0]  paddr;
    logic [edt_pkg::DATA_W-1:0]  pwdata;
    logic [edt_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        i_in_valid;
    edt_pkg::t_in_item           i_in_data;
    logic                        o_in_stall;
    logic                        o_out_valid;
    edt_pkg::t_out_item          o_out_data;
    logic                        i_out_stall;

    escaped_delimiter_tokenizer_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    // tokenizer shadow state
    logic [255:0] delim_map;
    logic         esc_on;
    logic         tok_open;
    logic         esc_wait;
    logic         token_nonempty;

    edt_pkg::t_out_item step_out[$];
    edt_pkg::t_out_item tokens_due[$];
    int           error_count;
    bit           quiet_mode;
    bit           hold_req;

    t_dir_row dir_rows [0:24] = '{
        '{1'b0, '{8'h00, 1'b0, 1'b1}, 3'd1,
            '{8'h00, edt_pkg::KIND_END_TEXT, 1'b1}, NO_RES, NO_RES},
        '{1'b0, '{8'h20, 1'b1, 1'b0}, 3'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h61, 1'b1, 1'b0}, 3'd1,
            '{8'h61, edt_pkg::KIND_CHAR, 1'b1}, NO_RES, NO_RES},
        '{1'b0, '{8'h2C, 1'b1, 1'b0}, 3'd1,
            '{8'h00, edt_pkg::KIND_END_TOKEN, 1'b1}, NO_RES, NO_RES},
        '{1'b0, '{8'h2C, 1'b1, 1'b0}, 3'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'hFF, 1'b1, 1'b0}, 3'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h5C, 1'b1, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h20, 1'b1, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h5C, 1'b1, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h5C, 1'b1, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h5C, 1'b1, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h7A, 1'b1, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h00, 1'b1, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'hA5, 1'b0, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h80, 1'b1, 1'b1}, 3'd3, '{8'h80, edt_pkg::KIND_CHAR, 1'b0},
            '{8'h00, edt_pkg::KIND_END_TOKEN, 1'b0},
            '{8'h00, edt_pkg::KIND_END_TEXT, 1'b1}},
        '{1'b0, '{8'h5C, 1'b1, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h00, 1'b0, 1'b1}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h5C, 1'b1, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h71, 1'b1, 1'b1}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h41, 1'b1, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h09, 1'b1, 1'b1}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'hFE, 1'b1, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h5C, 1'b1, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b1, '{8'h5C, 1'b1, 1'b0}, USE_MODEL, NO_RES, NO_RES, NO_RES},
        '{1'b0, '{8'h00, 1'b0, 1'b1}, USE_MODEL, NO_RES, NO_RES, NO_RES}
    };

    function automatic void add_result(input logic [7:0] b, input logic [1:0] k);
        edt_pkg::t_out_item r;
        r.out_byte    = b;
        r.kind        = k;
        r.last_of_run = 1'b0;
        step_out = {step_out, r};
    endfunction

    function automatic void tokenize_byte(input edt_pkg::t_in_item it);
        logic [7:0] c;
        c = it.in_byte;
        step_out.delete();
        if (it.byte_valid) begin
            if (delim_map[c]) begin
                if (tok_open && esc_wait) begin
                    esc_wait = 1'b0;
                    add_result(c, edt_pkg::KIND_CHAR);
                    token_nonempty = 1'b1;
                end else if (tok_open) begin
                    if (token_nonempty) add_result(8'h00, edt_pkg::KIND_END_TOKEN);
                    tok_open       = 1'b0;
                    token_nonempty = 1'b0;
                end
            end else if (esc_on && c == edt_pkg::BACKSLASH) begin
                tok_open = 1'b1;
                if (esc_wait) begin
                    esc_wait = 1'b0;
                    add_result(c, edt_pkg::KIND_CHAR);
                    token_nonempty = 1'b1;
                end else begin
                    esc_wait = 1'b1;
                end
            end else begin
                tok_open = 1'b1;
                if (esc_wait) begin
                    esc_wait = 1'b0;
                    add_result(edt_pkg::BACKSLASH, edt_pkg::KIND_CHAR);
                end
                add_result(c, edt_pkg::KIND_CHAR);
                token_nonempty = 1'b1;
            end
        end
        if (it.end_of_text) begin
            if (esc_wait) begin
                add_result(edt_pkg::BACKSLASH, edt_pkg::KIND_CHAR);
                token_nonempty = 1'b1;
            end
            if (token_nonempty) add_result(8'h00, edt_pkg::KIND_END_TOKEN);
            add_result(8'h00, edt_pkg::KIND_END_TEXT);
            tok_open       = 1'b0;
            esc_wait       = 1'b0;
            token_nonempty = 1'b0;
        end
        if (step_out.size() > 0) begin
            step_out[step_out.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    function automatic logic [7:0] pick_delim();
        logic [7:0] b;
        b = 8'h00;
        for (int k = 0; k < 32; k++) begin
            b = 8'($urandom);
            if (delim_map[b]) return b;
        end
        return b;
    endfunction

    function automatic edt_pkg::t_in_item gen_text_item();
        edt_pkg::t_in_item it;
        int unsigned r;
        r = $urandom_range(0, 99);
        it.in_byte     = 8'($urandom);
        it.byte_valid  = 1'b1;
        it.end_of_text = 1'b0;
        if (r < 40)      it.in_byte = 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 58) it.in_byte = pick_delim();
        else if (r < 71) it.in_byte = edt_pkg::BACKSLASH;
        else if (r < 85) it.in_byte = 8'($urandom);
        else if (r < 92) it.end_of_text = 1'b1;
        else if (r < 96) begin
            it.byte_valid  = 1'b0;
            it.end_of_text = 1'b1;
        end else begin
            it.byte_valid  = 1'b0;
        end
        return it;
    endfunction

    task automatic reg_write(input logic [edt_pkg::REG_IDX_W-1:0] idx,
                             input logic [edt_pkg::DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            edt_pkg::REG_DELIM_MASK_0: delim_map[63:0]    = value;
            edt_pkg::REG_DELIM_MASK_1: delim_map[127:64]  = value;
            edt_pkg::REG_DELIM_MASK_2: delim_map[191:128] = value;
            edt_pkg::REG_DELIM_MASK_3: delim_map[255:192] = value;
            edt_pkg::REG_ESCAPE_EN:    esc_on             = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(input logic [63:0] m0, input logic [63:0] m1,
                               input logic [63:0] m2, input logic [63:0] m3,
                               input logic esc);
        reg_write(edt_pkg::REG_DELIM_MASK_0, m0);
        reg_write(edt_pkg::REG_DELIM_MASK_1, m1);
        reg_write(edt_pkg::REG_DELIM_MASK_2, m2);
        reg_write(edt_pkg::REG_DELIM_MASK_3, m3);
        reg_write(edt_pkg::REG_ESCAPE_EN, {63'd0, esc});
    endtask

    task automatic drain_tokens();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic offer_item(input edt_pkg::t_in_item it);
        int unsigned gap;
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        tokenize_byte(it);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side backpressure
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        edt_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tokens_due.size() == 0) begin
                $error("unexpected result transfer: byte %0h kind %0d",
                       o_out_data.out_byte, o_out_data.kind);
                error_count++;
            end else begin
                want = tokens_due.pop_front();
                if (o_out_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, o_out_data.out_byte);
                    error_count++;
                end
                if (o_out_data.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_out_data.kind);
                    error_count++;
                end
                if (o_out_data.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last_of_run, o_out_data.last_of_run);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_dir_row          row;
        edt_pkg::t_in_item it;
        int unsigned       sent;
        logic [63:0]       m [4];

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        delim_map      = '0;
        esc_on         = 1'b0;
        tok_open       = 1'b0;
        esc_wait       = 1'b0;
        token_nonempty = 1'b0;
        error_count    = 0;
        quiet_mode     = 1'b0;
        hold_req       = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: NUL, tab, space, comma and 0xFF are delimiters
        load_config(64'h0000_1001_0000_0201, 64'd0, 64'd0, 64'h8000_0000_0000_0000, 1'b1);
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.esc_off) begin
                drain_tokens();
                reg_write(edt_pkg::REG_ESCAPE_EN, 64'd0);
            end
            offer_item(row.item);
            if (row.n_fix == USE_MODEL) begin
                tokens_due = {tokens_due, step_out};
            end else begin
                if (row.n_fix > 0) tokens_due = {tokens_due, row.fix0};
                if (row.n_fix > 1) tokens_due = {tokens_due, row.fix1};
                if (row.n_fix > 2) tokens_due = {tokens_due, row.fix2};
            end
        end
        drain_tokens();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: load_config(64'd0, 64'd0, 64'd0, 64'd0, 1'b1);
                1: load_config('1, '1, '1, '1, 1'b0);
                2: load_config(64'h0000_1001_0000_2601, 64'd0, 64'd0,
                               64'h8000_0000_0000_0000, 1'b1);
                3: begin
                    foreach (m[k]) m[k] = {$urandom, $urandom};
                    load_config(m[0], m[1], m[2], m[3], 1'b1);
                end
                default: begin
                    foreach (m[k]) m[k] = {$urandom, $urandom} & {$urandom, $urandom};
                    load_config(m[0], m[1], m[2], m[3], 1'b0);
                    quiet_mode = 1'b1;
                end
            endcase
            if (p == 2) hold_req = 1'b1;
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                it = gen_text_item();
                offer_item(it);
                tokens_due = {tokens_due, step_out};
                sent++;
            end
            drain_tokens();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && tokens_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/edt_pkg.sv
rtl/core/edt_regs.sv
rtl/core/edt_front.sv
rtl/core/edt_queue.sv
rtl/core/edt_back.sv
rtl/core/escaped_delimiter_tokenizer_core.sv
verif/escaped_delimiter_tokenizer_core_test.sv
